// File: rtl/csnl_pkg.sv
package csnl_pkg;

  // Largest face edge that the tile coordinates can address.
  localparam int unsigned MaxGrid = 64;

  localparam int unsigned FaceW = 3;
  localparam int unsigned CoordW = 6;
  localparam int unsigned SizeW = 7;
  localparam int unsigned StepW = 2;

  localparam logic [FaceW-1:0] LastFace = 3'd5;
  localparam logic [SizeW-1:0] MaxGridSize = SizeW'(MaxGrid);

  // Face sides: left is column 0, right the last column, bottom row 0, top the last row.
  typedef enum logic [1:0] {
    SIDE_L = 2'd0,
    SIDE_R = 2'd1,
    SIDE_B = 2'd2,
    SIDE_T = 2'd3
  } side_e;

  // One edge crossing: face entered, side it is entered from, reversed position.
  typedef struct packed {
    logic [FaceW-1:0] face;
    side_e            side;
    logic             rev;
  } edge_t;

  // A tile on the cube.
  typedef struct packed {
    logic [FaceW-1:0]  face;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } loc_t;

  localparam edge_t EDGE_TAB [0:5][0:3] = '{
    '{'{3'd4, SIDE_R, 1'b0}, '{3'd1, SIDE_L, 1'b0}, '{3'd5, SIDE_T, 1'b0}, '{3'd3, SIDE_B, 1'b0}},
    '{'{3'd0, SIDE_R, 1'b0}, '{3'd2, SIDE_L, 1'b0}, '{3'd5, SIDE_R, 1'b1}, '{3'd3, SIDE_R, 1'b0}},
    '{'{3'd1, SIDE_R, 1'b0}, '{3'd4, SIDE_L, 1'b0}, '{3'd5, SIDE_B, 1'b1}, '{3'd3, SIDE_T, 1'b1}},
    '{'{3'd4, SIDE_T, 1'b1}, '{3'd1, SIDE_T, 1'b0}, '{3'd0, SIDE_T, 1'b0}, '{3'd2, SIDE_T, 1'b1}},
    '{'{3'd2, SIDE_R, 1'b0}, '{3'd0, SIDE_L, 1'b0}, '{3'd5, SIDE_L, 1'b0}, '{3'd3, SIDE_L, 1'b1}},
    '{'{3'd4, SIDE_B, 1'b0}, '{3'd1, SIDE_B, 1'b1}, '{3'd2, SIDE_B, 1'b1}, '{3'd0, SIDE_B, 1'b0}}
  };

  // Edge table lookup; faces above the last one never reach a real crossing.
  function automatic edge_t edge_lookup(logic [FaceW-1:0] face, side_e side);
    edge_t e;
    e = '{3'd0, SIDE_L, 1'b0};
    if (face <= LastFace) begin
      e = EDGE_TAB[face][side];
    end
    return e;
  endfunction

  // Step code to signed step: 01 is +1, 00 is 0, both negative codes are -1.
  function automatic logic signed [StepW-1:0] step_decode(logic [StepW-1:0] code);
    logic signed [StepW-1:0] s;
    case (code)
      2'b00:   s = 2'sd0;
      2'b01:   s = 2'sd1;
      default: s = -2'sd1;
    endcase
    return s;
  endfunction

  // True when moving coordinate p by d leaves 0..n-1.
  function automatic logic leaves(logic [CoordW-1:0] p, logic signed [StepW-1:0] d,
                                  logic [SizeW-1:0] n);
    logic signed [SizeW:0] q;
    q = $signed({2'b00, p}) + $signed({{(SizeW-1){d[StepW-1]}}, d});
    return (q < 0) || (q >= $signed({1'b0, n}));
  endfunction

  // One single-axis step, crossing an edge through the table when needed.
  function automatic loc_t step_one(logic [SizeW-1:0] n, loc_t p,
                                    logic signed [StepW-1:0] dx,
                                    logic signed [StepW-1:0] dy);
    logic signed [SizeW:0] nx;
    logic signed [SizeW:0] ny;
    logic signed [SizeW:0] lim;
    logic [SizeW-1:0]      last;
    logic [SizeW-1:0]      pos;
    side_e                 side;
    edge_t                 e;
    loc_t                  r;
    nx   = $signed({2'b00, p.col}) + $signed({{(SizeW-1){dx[StepW-1]}}, dx});
    ny   = $signed({2'b00, p.row}) + $signed({{(SizeW-1){dy[StepW-1]}}, dy});
    lim  = $signed({1'b0, n});
    last = n - SizeW'(1);
    r    = p;
    if (nx >= 0 && nx < lim && ny >= 0 && ny < lim) begin
      r.col = nx[CoordW-1:0];
      r.row = ny[CoordW-1:0];
    end else begin
      if (nx < 0) begin
        side = SIDE_L;
      end else if (nx >= lim) begin
        side = SIDE_R;
      end else if (ny < 0) begin
        side = SIDE_B;
      end else begin
        side = SIDE_T;
      end
      e = edge_lookup(p.face, side);
      if (side == SIDE_L || side == SIDE_R) begin
        pos = {1'b0, p.row};
      end else begin
        pos = {1'b0, p.col};
      end
      if (e.rev) begin
        pos = last - pos;
      end
      r.face = e.face;
      case (e.side)
        SIDE_L: begin
          r.col = '0;
          r.row = pos[CoordW-1:0];
        end
        SIDE_R: begin
          r.col = last[CoordW-1:0];
          r.row = pos[CoordW-1:0];
        end
        SIDE_B: begin
          r.col = pos[CoordW-1:0];
          r.row = '0;
        end
        default: begin
          r.col = pos[CoordW-1:0];
          r.row = last[CoordW-1:0];
        end
      endcase
    end
    return r;
  endfunction

endpackage

// File: rtl/csnl_if.sv
// Query item channel.
interface csnl_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [csnl_pkg::FaceW-1:0]             cell_face;
  logic [csnl_pkg::CoordW-1:0]            cell_col;
  logic [csnl_pkg::CoordW-1:0]            cell_row;
  logic signed [csnl_pkg::StepW-1:0]      step_x;
  logic signed [csnl_pkg::StepW-1:0]      step_y;

  modport source (output valid, cell_face, cell_col, cell_row, step_x, step_y, input ready);
  modport sink   (input valid, cell_face, cell_col, cell_row, step_x, step_y, output ready);
endinterface

// Result item channel.
interface csnl_out_if;
  logic                        valid;
  logic                        ready;
  logic [csnl_pkg::FaceW-1:0]  neighbor_face;
  logic [csnl_pkg::CoordW-1:0] neighbor_col;
  logic [csnl_pkg::CoordW-1:0] neighbor_row;
  logic                        bad_input;

  modport source (output valid, neighbor_face, neighbor_col, neighbor_row, bad_input,
                  input ready);
  modport sink   (input valid, neighbor_face, neighbor_col, neighbor_row, bad_input,
                  output ready);
endinterface

// Grid size register write channel.
interface csnl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [csnl_pkg::SizeW-1:0] grid_size;

  modport source (output valid, grid_size, input ready);
  modport sink   (input valid, grid_size, output ready);
endinterface

// File: rtl/cubed_sphere_neighbor_locate.sv
// Channel   | Dir | Handshake    | Payload
// in_i      | in  | valid/ready  | cell_face, cell_col, cell_row, step_x, step_y
// out_o     | out | valid/ready  | neighbor_face, neighbor_col, neighbor_row, bad_input
// cfg_i     | in  | valid/ready  | grid_size (always ready)
//
// One item per clock sustained while the result side is ready. Each item passes through
// the input register and then the result register, with the edge-table walk of both
// single steps between them. Reset clears both valid bits and sets the grid size to 1.
// A stalled result holds in the output register; the input register keeps accepting
// while the result register can move on.
module cubed_sphere_neighbor_locate (
  input  logic       clk_i,
  input  logic       rst_ni,
  csnl_in_if.sink    in_i,
  csnl_out_if.source out_o,
  csnl_cfg_if.sink   cfg_i
);

  logic [csnl_pkg::SizeW-1:0] grid_size_q;

  logic                               s1_valid_q;
  logic [csnl_pkg::FaceW-1:0]         s1_face_q;
  logic [csnl_pkg::CoordW-1:0]        s1_col_q;
  logic [csnl_pkg::CoordW-1:0]        s1_row_q;
  logic signed [csnl_pkg::StepW-1:0]  s1_dx_q;
  logic signed [csnl_pkg::StepW-1:0]  s1_dy_q;

  logic                  out_valid_q;
  csnl_pkg::loc_t        out_loc_q;
  logic                  out_bad_q;

  logic                  out_take;
  logic                  s1_take;
  logic [csnl_pkg::SizeW-1:0] size_eff;
  logic                  bad_d;
  logic                  lv_x;
  logic                  lv_y;
  logic                  both;
  logic                  y_first;
  logic signed [csnl_pkg::StepW-1:0] a_dx, a_dy, b_dx, b_dy;
  csnl_pkg::loc_t        start_loc;
  csnl_pkg::loc_t        mid_loc;
  csnl_pkg::loc_t        end_loc;
  csnl_pkg::loc_t        res_d;

  // Handshakes: the result register frees up when empty or taken.
  assign out_take   = !out_valid_q || out_o.ready;
  assign s1_take    = !s1_valid_q || out_take;
  assign in_i.ready = s1_take;
  assign cfg_i.ready = 1'b1;

  // Grid size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= csnl_pkg::SizeW'(1);
    end else if (cfg_i.valid) begin
      grid_size_q <= cfg_i.grid_size;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_take) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && in_i.valid) begin
      s1_face_q <= in_i.cell_face;
      s1_col_q  <= in_i.cell_col;
      s1_row_q  <= in_i.cell_row;
      s1_dx_q   <= csnl_pkg::step_decode(in_i.step_x);
      s1_dy_q   <= csnl_pkg::step_decode(in_i.step_y);
    end
  end

  // Effective size saturates at the largest grid.
  assign size_eff = (grid_size_q > csnl_pkg::MaxGridSize) ? csnl_pkg::MaxGridSize
                                                          : grid_size_q;

  assign bad_d = (s1_face_q > csnl_pkg::LastFace) ||
                 ({1'b0, s1_col_q} >= size_eff) ||
                 ({1'b0, s1_row_q} >= size_eff);

  // A diagonal goes x then y, or y then x when only the x step leaves the face.
  // At a cube corner the y step is dropped.
  always_comb begin
    lv_x    = csnl_pkg::leaves(s1_col_q, s1_dx_q, size_eff);
    lv_y    = csnl_pkg::leaves(s1_row_q, s1_dy_q, size_eff);
    both    = (s1_dx_q != 2'sd0) && (s1_dy_q != 2'sd0);
    y_first = both && lv_x && !lv_y;
    if (y_first) begin
      a_dx = 2'sd0;
      a_dy = s1_dy_q;
      b_dx = s1_dx_q;
      b_dy = 2'sd0;
    end else begin
      a_dx = s1_dx_q;
      a_dy = 2'sd0;
      b_dx = 2'sd0;
      b_dy = (both && lv_x && lv_y) ? 2'sd0 : s1_dy_q;
    end
    start_loc = '{face: s1_face_q, col: s1_col_q, row: s1_row_q};
    mid_loc   = csnl_pkg::step_one(size_eff, start_loc, a_dx, a_dy);
    end_loc   = csnl_pkg::step_one(size_eff, mid_loc, b_dx, b_dy);
    res_d     = bad_d ? '0 : end_loc;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_valid_q) begin
      out_loc_q <= res_d;
      out_bad_q <= bad_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.neighbor_face = out_loc_q.face;
  assign out_o.neighbor_col  = out_loc_q.col;
  assign out_o.neighbor_row  = out_loc_q.row;
  assign out_o.bad_input     = out_bad_q;

endmodule

// File: sim/tb_cubed_sphere_neighbor_locate.sv
`timescale 1ns / 100ps

module tb_cubed_sphere_neighbor_locate;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 3;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned NUM_PHASES      = 14;
  localparam int unsigned NUM_PROBES      = 25;

  // Step codes as they travel on the query channel.
  localparam logic [csnl_pkg::StepW-1:0] STEP_ZERO    = 2'b00;
  localparam logic [csnl_pkg::StepW-1:0] STEP_POS     = 2'b01;
  localparam logic [csnl_pkg::StepW-1:0] STEP_NEG_TWO = 2'b10;
  localparam logic [csnl_pkg::StepW-1:0] STEP_NEG     = 2'b11;

  typedef struct packed {
    logic [csnl_pkg::FaceW-1:0]  face;
    logic [csnl_pkg::CoordW-1:0] col;
    logic [csnl_pkg::CoordW-1:0] row;
    logic                        bad;
  } neighbor_t;

  typedef struct packed {
    logic [csnl_pkg::FaceW-1:0] face;
    csnl_pkg::side_e            side;
    logic                       rev;
  } crossing_t;

  typedef struct packed {
    logic [csnl_pkg::SizeW-1:0]  grid;
    logic [csnl_pkg::FaceW-1:0]  face;
    logic [csnl_pkg::CoordW-1:0] col;
    logic [csnl_pkg::CoordW-1:0] row;
    logic [csnl_pkg::StepW-1:0]  sx;
    logic [csnl_pkg::StepW-1:0]  sy;
    logic                        typed;
    neighbor_t                   res;
  } probe_t;

  localparam neighbor_t RES_NONE = '0;
  localparam neighbor_t RES_BAD  = '{3'd0, 6'd0, 6'd0, 1'b1};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  csnl_in_if  in_ch ();
  csnl_out_if out_ch ();
  csnl_cfg_if cfg_ch ();

  cubed_sphere_neighbor_locate uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  neighbor_t                  pending_results [$];
  logic [csnl_pkg::SizeW-1:0] cur_grid = 7'd1;
  int unsigned                cycle_cnt = 0;
  int unsigned                err_cnt = 0;
  int unsigned                results_checked = 0;
  int unsigned                queries_sent = 0;
  int unsigned                flagged_cnt = 0;
  int unsigned                crossing_cnt = 0;
  int unsigned                grid_writes = 0;

  // Hand-picked queries: reset size, extremes, corners, reversed edges and bad input.
  probe_t probes [NUM_PROBES] = '{
    '{7'd1,   3'd0, 6'd0,  6'd0,  STEP_ZERO,    STEP_ZERO, 1'b1, '{3'd0, 6'd0, 6'd0, 1'b0}},
    '{7'd1,   3'd0, 6'd0,  6'd0,  STEP_POS,     STEP_ZERO, 1'b0, RES_NONE},
    '{7'd1,   3'd3, 6'd0,  6'd0,  STEP_NEG_TWO, STEP_ZERO, 1'b0, RES_NONE},
    '{7'd1,   3'd5, 6'd0,  6'd0,  STEP_NEG,     STEP_NEG,  1'b0, RES_NONE},
    '{7'd1,   3'd2, 6'd0,  6'd0,  STEP_ZERO,    STEP_POS,  1'b0, RES_NONE},
    '{7'd1,   3'd6, 6'd0,  6'd0,  STEP_ZERO,    STEP_ZERO, 1'b1, RES_BAD},
    '{7'd1,   3'd0, 6'd1,  6'd0,  STEP_ZERO,    STEP_ZERO, 1'b1, RES_BAD},
    '{7'd0,   3'd0, 6'd0,  6'd0,  STEP_ZERO,    STEP_ZERO, 1'b1, RES_BAD},
    '{7'd0,   3'd5, 6'd0,  6'd0,  STEP_POS,     STEP_POS,  1'b1, RES_BAD},
    '{7'd64,  3'd5, 6'd63, 6'd63, STEP_ZERO,    STEP_ZERO, 1'b1, '{3'd5, 6'd63, 6'd63, 1'b0}},
    '{7'd64,  3'd7, 6'd63, 6'd63, STEP_POS,     STEP_POS,  1'b1, RES_BAD},
    '{7'd64,  3'd2, 6'd63, 6'd63, STEP_POS,     STEP_POS,  1'b0, RES_NONE},
    '{7'd64,  3'd0, 6'd0,  6'd10, STEP_NEG,     STEP_ZERO, 1'b0, RES_NONE},
    '{7'd64,  3'd1, 6'd5,  6'd0,  STEP_ZERO,    STEP_NEG,  1'b0, RES_NONE},
    '{7'd64,  3'd4, 6'd63, 6'd20, STEP_POS,     STEP_NEG,  1'b0, RES_NONE},
    '{7'd64,  3'd3, 6'd10, 6'd63, STEP_POS,     STEP_POS,  1'b0, RES_NONE},
    '{7'd64,  3'd2, 6'd30, 6'd40, STEP_POS,     STEP_POS,  1'b0, RES_NONE},
    '{7'd64,  3'd4, 6'd0,  6'd0,  STEP_NEG_TWO, STEP_NEG_TWO, 1'b0, RES_NONE},
    '{7'd127, 3'd0, 6'd63, 6'd63, STEP_ZERO,    STEP_ZERO, 1'b1, '{3'd0, 6'd63, 6'd63, 1'b0}},
    '{7'd127, 3'd5, 6'd63, 6'd0,  STEP_POS,     STEP_ZERO, 1'b0, RES_NONE},
    '{7'd100, 3'd1, 6'd63, 6'd63, STEP_ZERO,    STEP_POS,  1'b0, RES_NONE},
    '{7'd3,   3'd0, 6'd3,  6'd0,  STEP_ZERO,    STEP_ZERO, 1'b1, RES_BAD},
    '{7'd3,   3'd5, 6'd1,  6'd1,  STEP_NEG_TWO, STEP_NEG,  1'b0, RES_NONE},
    '{7'd2,   3'd3, 6'd1,  6'd1,  STEP_POS,     STEP_POS,  1'b0, RES_NONE},
    '{7'd2,   3'd0, 6'd0,  6'd1,  STEP_NEG,     STEP_POS,  1'b0, RES_NONE}
  };

  // Edge crossing seen from one face: face entered, side entered from, reversal.
  function automatic crossing_t cross_edge(logic [csnl_pkg::FaceW-1:0] face,
                                           csnl_pkg::side_e side);
    crossing_t c;
    case ({face, side})
      {3'd0, csnl_pkg::SIDE_L}: c = '{3'd4, csnl_pkg::SIDE_R, 1'b0};
      {3'd0, csnl_pkg::SIDE_R}: c = '{3'd1, csnl_pkg::SIDE_L, 1'b0};
      {3'd0, csnl_pkg::SIDE_B}: c = '{3'd5, csnl_pkg::SIDE_T, 1'b0};
      {3'd0, csnl_pkg::SIDE_T}: c = '{3'd3, csnl_pkg::SIDE_B, 1'b0};
      {3'd1, csnl_pkg::SIDE_L}: c = '{3'd0, csnl_pkg::SIDE_R, 1'b0};
      {3'd1, csnl_pkg::SIDE_R}: c = '{3'd2, csnl_pkg::SIDE_L, 1'b0};
      {3'd1, csnl_pkg::SIDE_B}: c = '{3'd5, csnl_pkg::SIDE_R, 1'b1};
      {3'd1, csnl_pkg::SIDE_T}: c = '{3'd3, csnl_pkg::SIDE_R, 1'b0};
      {3'd2, csnl_pkg::SIDE_L}: c = '{3'd1, csnl_pkg::SIDE_R, 1'b0};
      {3'd2, csnl_pkg::SIDE_R}: c = '{3'd4, csnl_pkg::SIDE_L, 1'b0};
      {3'd2, csnl_pkg::SIDE_B}: c = '{3'd5, csnl_pkg::SIDE_B, 1'b1};
      {3'd2, csnl_pkg::SIDE_T}: c = '{3'd3, csnl_pkg::SIDE_T, 1'b1};
      {3'd3, csnl_pkg::SIDE_L}: c = '{3'd4, csnl_pkg::SIDE_T, 1'b1};
      {3'd3, csnl_pkg::SIDE_R}: c = '{3'd1, csnl_pkg::SIDE_T, 1'b0};
      {3'd3, csnl_pkg::SIDE_B}: c = '{3'd0, csnl_pkg::SIDE_T, 1'b0};
      {3'd3, csnl_pkg::SIDE_T}: c = '{3'd2, csnl_pkg::SIDE_T, 1'b1};
      {3'd4, csnl_pkg::SIDE_L}: c = '{3'd2, csnl_pkg::SIDE_R, 1'b0};
      {3'd4, csnl_pkg::SIDE_R}: c = '{3'd0, csnl_pkg::SIDE_L, 1'b0};
      {3'd4, csnl_pkg::SIDE_B}: c = '{3'd5, csnl_pkg::SIDE_L, 1'b0};
      {3'd4, csnl_pkg::SIDE_T}: c = '{3'd3, csnl_pkg::SIDE_L, 1'b1};
      {3'd5, csnl_pkg::SIDE_L}: c = '{3'd4, csnl_pkg::SIDE_B, 1'b0};
      {3'd5, csnl_pkg::SIDE_R}: c = '{3'd1, csnl_pkg::SIDE_B, 1'b1};
      {3'd5, csnl_pkg::SIDE_B}: c = '{3'd2, csnl_pkg::SIDE_B, 1'b1};
      default:                  c = '{3'd0, csnl_pkg::SIDE_B, 1'b0};
    endcase
    return c;
  endfunction

  function automatic int step_amount(logic [csnl_pkg::StepW-1:0] code);
    int s;
    case (code)
      STEP_ZERO: s = 0;
      STEP_POS:  s = 1;
      default:   s = -1;
    endcase
    return s;
  endfunction

  // Move one tile along one axis, walking over the face edge when it is left.
  function automatic void walk_tile(input int n, inout int f, inout int x, inout int y,
                                    input int dx, input int dy);
    int              nx;
    int              ny;
    int              pos;
    csnl_pkg::side_e side;
    crossing_t       c;
    nx = x + dx;
    ny = y + dy;
    if (nx >= 0 && nx < n && ny >= 0 && ny < n) begin
      x = nx;
      y = ny;
      return;
    end
    if (nx < 0) begin
      side = csnl_pkg::SIDE_L;
    end else if (nx >= n) begin
      side = csnl_pkg::SIDE_R;
    end else if (ny < 0) begin
      side = csnl_pkg::SIDE_B;
    end else begin
      side = csnl_pkg::SIDE_T;
    end
    c   = cross_edge(f[csnl_pkg::FaceW-1:0], side);
    pos = (side == csnl_pkg::SIDE_L || side == csnl_pkg::SIDE_R) ? y : x;
    if (c.rev) begin
      pos = n - 1 - pos;
    end
    f = int'(c.face);
    case (c.side)
      csnl_pkg::SIDE_L: begin
        x = 0;
        y = pos;
      end
      csnl_pkg::SIDE_R: begin
        x = n - 1;
        y = pos;
      end
      csnl_pkg::SIDE_B: begin
        x = pos;
        y = 0;
      end
      default: begin
        x = pos;
        y = n - 1;
      end
    endcase
  endfunction

  // Expected neighbor for one query at a given grid size register value.
  function automatic neighbor_t predict_neighbor(int gsz,
                                                 logic [csnl_pkg::FaceW-1:0] face,
                                                 logic [csnl_pkg::CoordW-1:0] col,
                                                 logic [csnl_pkg::CoordW-1:0] row,
                                                 logic [csnl_pkg::StepW-1:0] sx,
                                                 logic [csnl_pkg::StepW-1:0] sy);
    int        n;
    int        f;
    int        x;
    int        y;
    int        dx;
    int        dy;
    neighbor_t r;
    n  = (gsz > int'(csnl_pkg::MaxGrid)) ? int'(csnl_pkg::MaxGrid) : gsz;
    dx = step_amount(sx);
    dy = step_amount(sy);
    r  = '0;
    if (face > csnl_pkg::LastFace || int'(col) >= n || int'(row) >= n) begin
      r.bad = 1'b1;
      return r;
    end
    f = int'(face);
    x = int'(col);
    y = int'(row);
    // Diagonals go x first unless x alone leaves the face; at a corner only x applies.
    if (dx == 0 || dy == 0) begin
      walk_tile(n, f, x, y, dx, dy);
    end else if (x + dx >= 0 && x + dx < n) begin
      walk_tile(n, f, x, y, dx, 0);
      walk_tile(n, f, x, y, 0, dy);
    end else if (y + dy >= 0 && y + dy < n) begin
      walk_tile(n, f, x, y, 0, dy);
      walk_tile(n, f, x, y, dx, 0);
    end else begin
      walk_tile(n, f, x, y, dx, 0);
    end
    r.face = f[csnl_pkg::FaceW-1:0];
    r.col  = x[csnl_pkg::CoordW-1:0];
    r.row  = y[csnl_pkg::CoordW-1:0];
    return r;
  endfunction

  // Present one query item and record its expected result once accepted.
  task automatic send_query(input logic [csnl_pkg::FaceW-1:0] face,
                            input logic [csnl_pkg::CoordW-1:0] col,
                            input logic [csnl_pkg::CoordW-1:0] row,
                            input logic [csnl_pkg::StepW-1:0] sx,
                            input logic [csnl_pkg::StepW-1:0] sy, input logic typed,
                            input neighbor_t given);
    neighbor_t want;
    in_ch.valid     <= 1'b1;
    in_ch.cell_face <= face;
    in_ch.cell_col  <= col;
    in_ch.cell_row  <= row;
    in_ch.step_x    <= sx;
    in_ch.step_y    <= sy;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    want = typed ? given : predict_neighbor(int'(cur_grid), face, col, row, sx, sy);
    pending_results = {pending_results, want};
    queries_sent++;
    if (want.bad) begin
      flagged_cnt++;
    end else if (want.face != face) begin
      crossing_cnt++;
    end
  endtask

  // Grid size changes only once every outstanding result has come back.
  task automatic write_grid(input logic [csnl_pkg::SizeW-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.grid_size <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    cur_grid = value;
    grid_writes++;
  endtask

  // Coordinates are pulled toward the face edges, where the crossings live.
  function automatic logic [csnl_pkg::CoordW-1:0] pick_coord(int n);
    int v;
    case ($urandom_range(0, 4))
      0:       v = 0;
      1:       v = n - 1;
      2:       v = (n > 1) ? 1 : 0;
      3:       v = (n > 1) ? n - 2 : 0;
      default: v = $urandom_range(0, n - 1);
    endcase
    return v[csnl_pkg::CoordW-1:0];
  endfunction

  task automatic send_random(input int n);
    logic [csnl_pkg::FaceW-1:0]  face;
    logic [csnl_pkg::CoordW-1:0] col;
    logic [csnl_pkg::CoordW-1:0] row;
    logic [csnl_pkg::StepW-1:0]  sx;
    logic [csnl_pkg::StepW-1:0]  sy;
    // Mostly tiles on the grid; a small share of anything the fields can carry.
    if (n == 0 || $urandom_range(0, 99) < 8) begin
      face = csnl_pkg::FaceW'($urandom_range(0, 7));
      col  = csnl_pkg::CoordW'($urandom_range(0, 63));
      row  = csnl_pkg::CoordW'($urandom_range(0, 63));
    end else begin
      face = csnl_pkg::FaceW'($urandom_range(0, 5));
      col  = pick_coord(n);
      row  = pick_coord(n);
    end
    sx = csnl_pkg::StepW'($urandom_range(0, 3));
    sy = csnl_pkg::StepW'($urandom_range(0, 3));
    send_query(face, col, row, sx, sy, 1'b0, RES_NONE);
  endtask

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    neighbor_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d bad %0d",
                 $time, out_ch.neighbor_face, out_ch.neighbor_col, out_ch.neighbor_row,
                 out_ch.bad_input);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        report_field("neighbor_face", 8'(want.face), 8'(out_ch.neighbor_face));
        report_field("neighbor_col", 8'(want.col), 8'(out_ch.neighbor_col));
        report_field("neighbor_row", 8'(want.row), 8'(out_ch.neighbor_row));
        report_field("bad_input", 8'(want.bad), 8'(out_ch.bad_input));
        results_checked++;
      end
    end
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side back-pressure: free flow, light and heavy random stalls, a fixed beat.
  initial begin
    int unsigned stall_tick;
    stall_tick = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      stall_tick++;
      case ((stall_tick / 256) % 4)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 2) == 0);
        default: out_ch.ready <= ((stall_tick % 7) < 4);
      endcase
    end
  end

  // Query stimulus: directed table, then random phases over several grid sizes.
  initial begin
    int                         burst_left;
    int                         gap;
    int                         n_eff;
    int                         item_cnt;
    logic [csnl_pkg::SizeW-1:0] g;
    in_ch.valid      <= 1'b0;
    in_ch.cell_face  <= '0;
    in_ch.cell_col   <= '0;
    in_ch.cell_row   <= '0;
    in_ch.step_x     <= '0;
    in_ch.step_y     <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.grid_size <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_PROBES; i++) begin
      if (probes[i].grid != cur_grid) begin
        write_grid(probes[i].grid);
      end
      send_query(probes[i].face, probes[i].col, probes[i].row, probes[i].sx, probes[i].sy,
                 probes[i].typed, probes[i].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       g = 7'd64;
        1:       g = 7'd1;
        2:       g = 7'd2;
        3:       g = 7'd3;
        4:       g = 7'd5;
        5:       g = 7'd0;
        6:       g = 7'd127;
        7:       g = 7'd64;
        8:       g = 7'd17;
        9:       g = 7'd100;
        10:      g = 7'd8;
        11:      g = csnl_pkg::SizeW'($urandom_range(1, 64));
        12:      g = csnl_pkg::SizeW'($urandom_range(65, 127));
        default: g = 7'd64;
      endcase
      write_grid(g);
      n_eff      = (int'(g) > int'(csnl_pkg::MaxGrid)) ? int'(csnl_pkg::MaxGrid) : int'(g);
      item_cnt   = (g == 7'd0) ? 20 : ITEMS_PER_PHASE;
      burst_left = 0;
      for (int k = 0; k < item_cnt; k++) begin
        // Bursts of random length; some follow straight on, others after a short gap.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        send_random(n_eff);
        burst_left--;
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);

    $display("Sent %0d neighbor queries over %0d grid size writes; %0d results checked.",
             queries_sent, grid_writes, results_checked);
    $display("Of those, %0d were flagged out of range and %0d crossed onto another face.",
             flagged_cnt, crossing_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
